// ===== sv/max_flow_solver_defines.svh =====
// ----------------------------------------------------------------------------
// max_flow_solver_defines.svh
// Assertion macros for the max flow solver. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef MAX_FLOW_SOLVER_DEFINES_SVH
`define MAX_FLOW_SOLVER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MFS_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("max_flow_solver: same-cycle check failed");
// next-cycle implication
`define MFS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("max_flow_solver: next-cycle check failed");
`else
`define MFS_ASSERT_NOW(lbl, ck, rn, ante, cons)
`define MFS_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== sv/mfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared constants, sequencer codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package mfs_pkg;

	// default sizing
	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_EDGES_DEF    = 1024;
	localparam int SCALE_PHASES_DEF = 31;

	// fixed field widths
	localparam int VERTEX_W  = 6;
	localparam int CAP_W     = 31;
	localparam int RES_W     = 32;
	localparam int FLOW_W    = 42;
	localparam int MASK_W    = 64;
	localparam int VCOUNT_W  = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SINK         = 2'd2;

	// configuration reset values
	localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 7'd64;
	localparam logic [VERTEX_W-1:0] SOURCE_RST = 6'd0;
	localparam logic [VERTEX_W-1:0] SINK_RST   = 6'd63;

	// sequencer state codes (also the datapath operation)
	localparam int ST_W = 6;
	localparam logic [ST_W-1:0] ST_IDLE     = 6'd0;
	localparam logic [ST_W-1:0] ST_AP_RD1   = 6'd1;
	localparam logic [ST_W-1:0] ST_AP_WR1   = 6'd2;
	localparam logic [ST_W-1:0] ST_AP_RD2   = 6'd3;
	localparam logic [ST_W-1:0] ST_AP_WR2   = 6'd4;
	localparam logic [ST_W-1:0] ST_SV_INIT  = 6'd5;
	localparam logic [ST_W-1:0] ST_BF_INIT  = 6'd6;
	localparam logic [ST_W-1:0] ST_BF_POP   = 6'd7;
	localparam logic [ST_W-1:0] ST_BF_VTX   = 6'd8;
	localparam logic [ST_W-1:0] ST_BF_VTX2  = 6'd9;
	localparam logic [ST_W-1:0] ST_BF_EDGE  = 6'd10;
	localparam logic [ST_W-1:0] ST_BF_EDGE2 = 6'd11;
	localparam logic [ST_W-1:0] ST_DF_INIT  = 6'd12;
	localparam logic [ST_W-1:0] ST_DF_TOP   = 6'd13;
	localparam logic [ST_W-1:0] ST_DF_CUR   = 6'd14;
	localparam logic [ST_W-1:0] ST_DF_SCAN  = 6'd15;
	localparam logic [ST_W-1:0] ST_DF_SCAN2 = 6'd16;
	localparam logic [ST_W-1:0] ST_DF_SCAN3 = 6'd17;
	localparam logic [ST_W-1:0] ST_DF_FAIL  = 6'd18;
	localparam logic [ST_W-1:0] ST_DF_POP   = 6'd19;
	localparam logic [ST_W-1:0] ST_DF_POP2  = 6'd20;
	localparam logic [ST_W-1:0] ST_PM_INIT  = 6'd21;
	localparam logic [ST_W-1:0] ST_PM_RD    = 6'd22;
	localparam logic [ST_W-1:0] ST_PM_RE    = 6'd23;
	localparam logic [ST_W-1:0] ST_PM_MIN   = 6'd24;
	localparam logic [ST_W-1:0] ST_PU_INIT  = 6'd25;
	localparam logic [ST_W-1:0] ST_PU_RD    = 6'd26;
	localparam logic [ST_W-1:0] ST_PU_E     = 6'd27;
	localparam logic [ST_W-1:0] ST_PU_SUB   = 6'd28;
	localparam logic [ST_W-1:0] ST_PU_ADD   = 6'd29;
	localparam logic [ST_W-1:0] ST_FLOW_ADD = 6'd30;
	localparam logic [ST_W-1:0] ST_PH_NEXT  = 6'd31;
	localparam logic [ST_W-1:0] ST_FINISH   = 6'd32;
	localparam logic [ST_W-1:0] ST_DONE     = 6'd33;

	// controller to datapath
	typedef struct packed {
		logic [ST_W-1:0] op;
		logic            load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic drop;        // edge does not fit or names a vertex out of range
		logic last;        // latched edge ends the graph
		logic bad_st;      // source/sink out of range or equal
		logic bf_more;     // queue not empty and sink not yet leveled
		logic e_none;      // current edge pointer is the end marker
		logic v_is_t;      // walk reached the sink
		logic df_ok;       // scanned edge advances the walk
		logic depth_zero;  // path stack empty
		logic t_reached;   // sink got a level in the last search
		logic i_end;       // path index walked the whole stack
		logic phase_last;  // final scaling phase
	} sts_t;

endpackage

// ===== sv/mfs_ram.sv =====
// ----------------------------------------------------------------------------
// mfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfs_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/mfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// mfs_ctrl
// Sequencer for edge loading, leveling search, path walk and augmentation.
// ----------------------------------------------------------------------------
module mfs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  mfs_pkg::sts_t sts,
	output mfs_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);
	import mfs_pkg::*;

	logic [ST_W-1:0] state_q;
	logic [ST_W-1:0] state_d;

	// pick the next step from datapath status
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (start) state_d = ST_AP_RD1;
			ST_AP_RD1: begin
				if (!sts.drop)    state_d = ST_AP_WR1;
				else if (sts.last) state_d = ST_SV_INIT;
				else               state_d = ST_IDLE;
			end
			ST_AP_WR1:   state_d = ST_AP_RD2;
			ST_AP_RD2:   state_d = ST_AP_WR2;
			ST_AP_WR2:   state_d = sts.last ? ST_SV_INIT : ST_IDLE;
			ST_SV_INIT:  state_d = sts.bad_st ? ST_DONE : ST_BF_INIT;
			ST_BF_INIT:  state_d = ST_BF_POP;
			ST_BF_POP:   state_d = sts.bf_more ? ST_BF_VTX : ST_DF_INIT;
			ST_BF_VTX:   state_d = ST_BF_VTX2;
			ST_BF_VTX2:  state_d = ST_BF_EDGE;
			ST_BF_EDGE:  state_d = sts.e_none ? ST_BF_POP : ST_BF_EDGE2;
			ST_BF_EDGE2: state_d = ST_BF_EDGE;
			ST_DF_INIT:  state_d = ST_DF_TOP;
			ST_DF_TOP:   state_d = sts.v_is_t ? ST_PM_INIT : ST_DF_CUR;
			ST_DF_CUR:   state_d = ST_DF_SCAN;
			ST_DF_SCAN:  state_d = sts.e_none ? ST_DF_FAIL : ST_DF_SCAN2;
			ST_DF_SCAN2: state_d = ST_DF_SCAN3;
			ST_DF_SCAN3: state_d = sts.df_ok ? ST_DF_TOP : ST_DF_SCAN;
			ST_DF_FAIL: begin
				if (!sts.depth_zero)    state_d = ST_DF_POP;
				else if (sts.t_reached) state_d = ST_BF_INIT;
				else                    state_d = ST_PH_NEXT;
			end
			ST_DF_POP:   state_d = ST_DF_POP2;
			ST_DF_POP2:  state_d = ST_DF_TOP;
			ST_PM_INIT:  state_d = ST_PM_RD;
			ST_PM_RD:    state_d = sts.i_end ? ST_PU_INIT : ST_PM_RE;
			ST_PM_RE:    state_d = ST_PM_MIN;
			ST_PM_MIN:   state_d = ST_PM_RD;
			ST_PU_INIT:  state_d = ST_PU_RD;
			ST_PU_RD:    state_d = sts.i_end ? ST_FLOW_ADD : ST_PU_E;
			ST_PU_E:     state_d = ST_PU_SUB;
			ST_PU_SUB:   state_d = ST_PU_ADD;
			ST_PU_ADD:   state_d = ST_PU_RD;
			ST_FLOW_ADD: state_d = ST_DF_INIT;
			ST_PH_NEXT:  state_d = sts.phase_last ? ST_FINISH : ST_BF_INIT;
			ST_FINISH:   state_d = ST_DONE;
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// drive the datapath and the handshake
	assign cmd.op   = state_q;
	assign cmd.load = (state_q == ST_IDLE) && start;
	assign busy     = (state_q != ST_IDLE);
	assign done     = (state_q == ST_DONE);

endmodule

// ===== sv/mfs_datapath.sv =====
// ----------------------------------------------------------------------------
// mfs_datapath
// Edge tables, vertex tables, queue, path stack and the arithmetic of the
// solve, stepped one operation per cycle by the sequencer.
// ----------------------------------------------------------------------------
module mfs_datapath #(
	parameter int MaxVertices = mfs_pkg::MAX_VERTICES_DEF,
	parameter int MaxEdges    = mfs_pkg::MAX_EDGES_DEF,
	parameter int ScalePhases = mfs_pkg::SCALE_PHASES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mfs_pkg::cmd_t                  cmd,
	output mfs_pkg::sts_t                  sts,
	input  logic [mfs_pkg::VERTEX_W-1:0]   edge_from,
	input  logic [mfs_pkg::VERTEX_W-1:0]   edge_to,
	input  logic [mfs_pkg::CAP_W-1:0]      capacity,
	input  logic [mfs_pkg::CAP_W-1:0]      reverse_capacity,
	input  logic                           last_edge,
	input  logic                           cfg_we,
	input  logic [mfs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mfs_pkg::CFG_DAT_W-1:0]  cfg_wdata,
	output logic [mfs_pkg::FLOW_W-1:0]     max_flow,
	output logic [mfs_pkg::MASK_W-1:0]     source_side_mask
);
	import mfs_pkg::*;

	localparam int SlotCount = 2 * MaxEdges;
	localparam int SAW = $clog2(SlotCount);
	localparam int LKW = SAW + 1;
	localparam int VAW = $clog2(MaxVertices);
	localparam int CNW = VAW + 1;
	localparam int PHW = $clog2(ScalePhases + 1);
	localparam logic [LKW-1:0] NoEdge = LKW'(SlotCount);

	// configuration
	logic [VCOUNT_W-1:0] vcount_q;
	logic [VERTEX_W-1:0] src_q, snk_q;

	// latched edge beat
	logic [VERTEX_W-1:0] from_q, to_q;
	logic [CAP_W-1:0]    cap_q, rcap_q;
	logic                last_q;

	// control state
	logic [LKW-1:0]         et_q;
	logic [MaxVertices-1:0] first_vld_q, lvl_vld_q, cur_vld_q;

	// working registers
	logic [VAW-1:0]    v_q, w_q;
	logic [LKW-1:0]    e_q, nx_q;
	logic [RES_W-1:0]  r_q, p_q;
	logic [CNW-1:0]    lvl_v_q, head_q, tail_q, depth_q, i_q;
	logic [PHW-1:0]    phase_q;
	logic [FLOW_W-1:0] flow_q;
	logic [MASK_W-1:0] mask_q;

	// RAM ports
	logic           tgt_we, res_we, nxt_we, first_we, lvl_we, cur_we, que_we, stk_we;
	logic [SAW-1:0] tgt_wa, res_wa, nxt_wa, tgt_ra, res_ra, nxt_ra;
	logic [VAW-1:0] first_wa, lvl_wa, cur_wa, que_wa, stk_wa;
	logic [VAW-1:0] first_ra, lvl_ra, cur_ra, que_ra, stk_ra;
	logic [VAW-1:0] tgt_wd, tgt_rd, que_wd, que_rd;
	logic [RES_W-1:0] res_wd, res_rd;
	logic [LKW-1:0] nxt_wd, nxt_rd, first_wd, first_rd, cur_wd, cur_rd;
	logic [CNW-1:0] lvl_wd, lvl_rd;
	logic [SAW-1:0] stk_wd, stk_rd;

	// derived values
	logic [CNW-1:0]    n_eff;
	logic [VAW-1:0]    from_v, to_v, s_v, t_v, fv;
	logic [LKW-1:0]    first_eff;
	logic [PHW-1:0]    shift;
	logic [CNW-1:0]    lvl_w;
	logic              bf_ok, df_ok;
	logic [CNW-1:0]    depth_m1;
	logic [MASK_W-1:0] cut_mask;
	logic [MASK_W-1:0] st_mask;

	assign n_eff = (32'(vcount_q) > 32'(MaxVertices)) ? CNW'(MaxVertices)
	                                                   : CNW'(vcount_q);
	assign from_v   = VAW'(from_q);
	assign to_v     = VAW'(to_q);
	assign s_v      = VAW'(src_q);
	assign t_v      = VAW'(snk_q);
	assign shift    = PHW'(ScalePhases - 1) - phase_q;
	assign depth_m1 = depth_q - CNW'(1);

	// list head seen through the valid bits
	always_comb begin
		fv = v_q;
		if (cmd.op == ST_AP_WR1) fv = from_v;
		if (cmd.op == ST_AP_WR2) fv = to_v;
	end
	assign first_eff = first_vld_q[fv] ? first_rd : NoEdge;

	// edge tests for leveling and walking
	assign bf_ok = (32'(tgt_rd) < 32'(n_eff)) && !lvl_vld_q[tgt_rd] &&
	               ((res_rd >> shift) != '0) && (32'(tail_q) < 32'(MaxVertices));
	assign lvl_w = lvl_vld_q[w_q] ? lvl_rd : '0;
	assign df_ok = (32'(w_q) < 32'(n_eff)) && (r_q != '0) &&
	               (lvl_w == lvl_v_q + CNW'(1)) && (32'(depth_q) < 32'(MaxVertices));

	// cut mask from final levels
	for (genvar gv = 0; gv < MASK_W; gv++) begin : g_mask
		if (gv < MaxVertices) begin : g_in
			assign cut_mask[gv] = lvl_vld_q[gv] && (CNW'(gv) < n_eff);
		end else begin : g_out
			assign cut_mask[gv] = 1'b0;
		end
	end

	// early-out mask: only a valid source equal to the sink marks a bit
	assign st_mask = ((32'(src_q) < 32'(n_eff)) && (src_q == snk_q))
	                 ? (MASK_W'(1) << src_q) : '0;

	// status to the sequencer
	assign sts.drop       = (32'(from_q) >= 32'(MaxVertices)) ||
	                        (32'(to_q) >= 32'(MaxVertices)) ||
	                        (32'(et_q) + 32'd2 > 32'(SlotCount));
	assign sts.last       = last_q;
	assign sts.bad_st     = (32'(src_q) >= 32'(n_eff)) || (32'(snk_q) >= 32'(n_eff)) ||
	                        (src_q == snk_q);
	assign sts.bf_more    = (head_q < tail_q) && !lvl_vld_q[t_v];
	assign sts.e_none     = (e_q >= NoEdge);
	assign sts.v_is_t     = (v_q == t_v);
	assign sts.df_ok      = df_ok;
	assign sts.depth_zero = (depth_q == '0);
	assign sts.t_reached  = lvl_vld_q[t_v];
	assign sts.i_end      = (i_q == depth_q);
	assign sts.phase_last = (phase_q == PHW'(ScalePhases - 1));

	// RAM address and write steering
	always_comb begin
		tgt_we = 1'b0; res_we = 1'b0; nxt_we = 1'b0; first_we = 1'b0;
		lvl_we = 1'b0; cur_we = 1'b0; que_we = 1'b0; stk_we = 1'b0;
		tgt_wa = e_q[SAW-1:0]; res_wa = e_q[SAW-1:0]; nxt_wa = e_q[SAW-1:0];
		tgt_ra = e_q[SAW-1:0]; res_ra = e_q[SAW-1:0]; nxt_ra = e_q[SAW-1:0];
		first_wa = from_v; lvl_wa = s_v; cur_wa = v_q; que_wa = tail_q[VAW-1:0];
		stk_wa = depth_q[VAW-1:0];
		first_ra = v_q; lvl_ra = v_q; cur_ra = v_q; que_ra = head_q[VAW-1:0];
		stk_ra = i_q[VAW-1:0];
		tgt_wd = to_v; res_wd = RES_W'(cap_q); nxt_wd = first_eff; first_wd = et_q;
		lvl_wd = CNW'(1); cur_wd = nx_q; que_wd = s_v; stk_wd = e_q[SAW-1:0];
		unique case (cmd.op)
			ST_AP_RD1: first_ra = from_v;
			ST_AP_WR1: begin
				tgt_we = 1'b1; res_we = 1'b1; nxt_we = 1'b1; first_we = 1'b1;
				tgt_wa = et_q[SAW-1:0]; res_wa = et_q[SAW-1:0]; nxt_wa = et_q[SAW-1:0];
			end
			ST_AP_RD2: first_ra = to_v;
			ST_AP_WR2: begin
				tgt_we = 1'b1; res_we = 1'b1; nxt_we = 1'b1; first_we = 1'b1;
				tgt_wa = et_q[SAW-1:0] | SAW'(1);
				res_wa = et_q[SAW-1:0] | SAW'(1);
				nxt_wa = et_q[SAW-1:0] | SAW'(1);
				tgt_wd = from_v; res_wd = RES_W'(rcap_q);
				first_wa = to_v; first_wd = et_q | LKW'(1);
			end
			ST_BF_INIT: begin
				lvl_we = 1'b1; que_we = 1'b1; que_wa = '0;
			end
			ST_BF_VTX: begin
				first_ra = que_rd; lvl_ra = que_rd;
			end
			ST_BF_EDGE2: begin
				if (bf_ok) begin
					que_we = 1'b1; que_wd = tgt_rd;
					lvl_we = 1'b1; lvl_wa = tgt_rd; lvl_wd = lvl_v_q + CNW'(1);
				end
			end
			ST_DF_SCAN2: lvl_ra = tgt_rd;
			ST_DF_SCAN3: begin
				if (df_ok) stk_we = 1'b1;
				else       cur_we = 1'b1;
			end
			ST_DF_FAIL: stk_ra = depth_m1[VAW-1:0];
			ST_DF_POP: begin
				tgt_ra = stk_rd ^ SAW'(1); nxt_ra = stk_rd;
			end
			ST_DF_POP2: begin
				cur_we = 1'b1; cur_wa = tgt_rd; cur_wd = nxt_rd;
			end
			ST_PM_RE: res_ra = stk_rd;
			ST_PU_E:  res_ra = stk_rd;
			ST_PU_SUB: begin
				res_we = 1'b1; res_wd = res_rd - p_q;
				res_ra = e_q[SAW-1:0] ^ SAW'(1);
			end
			ST_PU_ADD: begin
				res_we = 1'b1; res_wa = e_q[SAW-1:0] ^ SAW'(1); res_wd = res_rd + p_q;
			end
			default: ;
		endcase
	end

	// configuration, edge count and vertex valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q    <= VCOUNT_RST;
			src_q       <= SOURCE_RST;
			snk_q       <= SINK_RST;
			et_q        <= '0;
			first_vld_q <= '0;
			lvl_vld_q   <= '0;
			cur_vld_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_VERTEX_COUNT: vcount_q <= cfg_wdata;
					CFG_SOURCE:       src_q    <= cfg_wdata[VERTEX_W-1:0];
					CFG_SINK:         snk_q    <= cfg_wdata[VERTEX_W-1:0];
					default: ;
				endcase
			end
			unique case (cmd.op)
				ST_AP_WR1: first_vld_q[from_v] <= 1'b1;
				ST_AP_WR2: begin
					first_vld_q[to_v] <= 1'b1;
					et_q <= et_q + LKW'(2);
				end
				ST_BF_INIT: begin
					lvl_vld_q      <= '0;
					lvl_vld_q[s_v] <= 1'b1;
					cur_vld_q      <= '0;
				end
				ST_BF_EDGE2: if (bf_ok) lvl_vld_q[tgt_rd] <= 1'b1;
				ST_DF_SCAN3: if (!df_ok) cur_vld_q[v_q] <= 1'b1;
				ST_DF_POP2:  cur_vld_q[tgt_rd] <= 1'b1;
				ST_DONE: begin
					et_q        <= '0;
					first_vld_q <= '0;
					lvl_vld_q   <= '0;
					cur_vld_q   <= '0;
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			from_q <= edge_from;
			to_q   <= edge_to;
			cap_q  <= capacity;
			rcap_q <= reverse_capacity;
			last_q <= last_edge;
		end
		unique case (cmd.op)
			ST_SV_INIT: begin
				flow_q  <= '0;
				phase_q <= '0;
				mask_q  <= st_mask;
			end
			ST_BF_INIT: begin
				head_q <= '0;
				tail_q <= CNW'(1);
			end
			ST_BF_POP:  head_q <= head_q + CNW'(1);
			ST_BF_VTX:  v_q <= que_rd;
			ST_BF_VTX2: begin
				e_q     <= first_eff;
				lvl_v_q <= lvl_rd;
			end
			ST_BF_EDGE2: begin
				if (bf_ok) tail_q <= tail_q + CNW'(1);
				e_q <= nxt_rd;
			end
			ST_DF_INIT: begin
				depth_q <= '0;
				v_q     <= s_v;
			end
			ST_DF_CUR: begin
				e_q     <= cur_vld_q[v_q] ? cur_rd : first_eff;
				lvl_v_q <= lvl_rd;
			end
			ST_DF_SCAN2: begin
				w_q  <= tgt_rd;
				r_q  <= res_rd;
				nx_q <= nxt_rd;
			end
			ST_DF_SCAN3: begin
				if (df_ok) begin
					depth_q <= depth_q + CNW'(1);
					v_q     <= w_q;
				end else begin
					e_q <= nx_q;
				end
			end
			ST_DF_FAIL: if (depth_q != '0) depth_q <= depth_m1;
			ST_DF_POP:  e_q <= LKW'(stk_rd);
			ST_DF_POP2: v_q <= tgt_rd;
			ST_PM_INIT: begin
				p_q <= '1;
				i_q <= '0;
			end
			ST_PM_MIN: begin
				if (res_rd < p_q) p_q <= res_rd;
				i_q <= i_q + CNW'(1);
			end
			ST_PU_INIT: i_q <= '0;
			ST_PU_E:    e_q <= LKW'(stk_rd);
			ST_PU_ADD:  i_q <= i_q + CNW'(1);
			ST_FLOW_ADD: flow_q <= flow_q + FLOW_W'(p_q);
			ST_PH_NEXT:  phase_q <= phase_q + PHW'(1);
			ST_FINISH:   mask_q <= cut_mask;
			default: ;
		endcase
	end

	assign max_flow         = flow_q;
	assign source_side_mask = mask_q;

	// edge tables
	mfs_ram #(.Width(VAW), .Depth(SlotCount)) u_tgt (
		.clk(clk), .we(tgt_we), .waddr(tgt_wa), .wdata(tgt_wd),
		.raddr(tgt_ra), .rdata(tgt_rd)
	);
	mfs_ram #(.Width(RES_W), .Depth(SlotCount)) u_res (
		.clk(clk), .we(res_we), .waddr(res_wa), .wdata(res_wd),
		.raddr(res_ra), .rdata(res_rd)
	);
	mfs_ram #(.Width(LKW), .Depth(SlotCount)) u_nxt (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
		.raddr(nxt_ra), .rdata(nxt_rd)
	);

	// vertex tables
	mfs_ram #(.Width(LKW), .Depth(MaxVertices)) u_first (
		.clk(clk), .we(first_we), .waddr(first_wa), .wdata(first_wd),
		.raddr(first_ra), .rdata(first_rd)
	);
	mfs_ram #(.Width(CNW), .Depth(MaxVertices)) u_lvl (
		.clk(clk), .we(lvl_we), .waddr(lvl_wa), .wdata(lvl_wd),
		.raddr(lvl_ra), .rdata(lvl_rd)
	);
	mfs_ram #(.Width(LKW), .Depth(MaxVertices)) u_cur (
		.clk(clk), .we(cur_we), .waddr(cur_wa), .wdata(cur_wd),
		.raddr(cur_ra), .rdata(cur_rd)
	);

	// search queue and path stack
	mfs_ram #(.Width(VAW), .Depth(MaxVertices)) u_que (
		.clk(clk), .we(que_we), .waddr(que_wa), .wdata(que_wd),
		.raddr(que_ra), .rdata(que_rd)
	);
	mfs_ram #(.Width(SAW), .Depth(MaxVertices)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
		.raddr(stk_ra), .rdata(stk_rd)
	);

endmodule

// ===== sv/max_flow_solver.sv =====
// ----------------------------------------------------------------------------
// max_flow_solver
// Edge loader and capacity-scaling Dinic maximum flow / minimum cut solver.
// ----------------------------------------------------------------------------
// Each edge beat is taken when start is high and busy is low; the edge is
// linked into the residual tables by a list-head read and a table write for
// each direction (forward, then reverse), after which busy drops. An edge
// that does not fit or names a vertex out of range is dropped after the
// first list-head read and frees the input. A beat with last_edge set runs
// the solve before busy drops: its length depends on the graph, through the
// edges scanned and vertices taken off the queue in each leveling search, the
// edges scanned in each path walk, and the path edges when flow is pushed
// (first to find the bottleneck, then to update both residuals), and each
// table has a single read port. The result is presented on max_flow and
// source_side_mask for exactly one cycle with done high and must be captured
// then; the graph is cleared in that same cycle, so no clearing pass follows
// reset or a solve.
// ----------------------------------------------------------------------------
`include "max_flow_solver_defines.svh"

module max_flow_solver #(
	parameter int MAX_VERTICES = mfs_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = mfs_pkg::MAX_EDGES_DEF,
	parameter int SCALE_PHASES = mfs_pkg::SCALE_PHASES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [mfs_pkg::VERTEX_W-1:0]  edge_from,
	input  logic [mfs_pkg::VERTEX_W-1:0]  edge_to,
	input  logic [mfs_pkg::CAP_W-1:0]     capacity,
	input  logic [mfs_pkg::CAP_W-1:0]     reverse_capacity,
	input  logic                          last_edge,
	input  logic                          cfg_we,
	input  logic [mfs_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [mfs_pkg::CFG_DAT_W-1:0] cfg_wdata,
	output logic                          done,
	output logic [mfs_pkg::FLOW_W-1:0]    max_flow,
	output logic [mfs_pkg::MASK_W-1:0]    source_side_mask
);
	import mfs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	mfs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts),
		.cmd(cmd), .busy(busy), .done(done)
	);

	// tables and arithmetic
	mfs_datapath #(
		.MaxVertices(MAX_VERTICES),
		.MaxEdges(MAX_EDGES),
		.ScalePhases(SCALE_PHASES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.edge_from(edge_from), .edge_to(edge_to), .capacity(capacity),
		.reverse_capacity(reverse_capacity), .last_edge(last_edge),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.max_flow(max_flow), .source_side_mask(source_side_mask)
	);

	// a result beat only comes out of a solve and ends it
	`MFS_ASSERT_NOW(a_done_busy, clk, arst_n, done, busy)
	`MFS_ASSERT_NEXT(a_done_idle, clk, arst_n, done, !busy)
	// work begins only on an accepted edge beat
	`MFS_ASSERT_NOW(a_busy_rise, clk, arst_n, $rose(busy), $past(start))

endmodule
